FILE: hw/rtl/lcs_pkg.sv
// Shared types, microcode field codes and defaults for the linear congruence solver.
package lcs_pkg;

   localparam int DATA_WIDTH = 32;

   // datapath operations, one per microcode step
   typedef logic [3:0] op_type;
   localparam op_type OP_NOP       = 4'd0;
   localparam op_type OP_LOAD      = 4'd1;
   localparam op_type OP_DIV_EUCL  = 4'd2;
   localparam op_type OP_MUL_COEF  = 4'd3;
   localparam op_type OP_UPDATE    = 4'd4;
   localparam op_type OP_DIV_RHS   = 4'd5;
   localparam op_type OP_MUL_SOL   = 4'd6;
   localparam op_type OP_SET_OK    = 4'd7;
   localparam op_type OP_ZERO_MOD  = 4'd8;
   localparam op_type OP_SEND      = 4'd9;

   // what a step waits for before it executes
   typedef logic [1:0] hold_type;
   localparam hold_type HOLD_NONE = 2'd0;
   localparam hold_type HOLD_REQ  = 2'd1;
   localparam hold_type HOLD_UNIT = 2'd2;
   localparam hold_type HOLD_OUT  = 2'd3;

   // branch conditions, tested on the registers as they stand at the step
   typedef logic [2:0] br_type;
   localparam br_type BR_NONE    = 3'd0;
   localparam br_type BR_ALWAYS  = 3'd1;
   localparam br_type BR_M_ZERO  = 3'd2;
   localparam br_type BR_R1_ZERO = 3'd3;
   localparam br_type BR_REM_NZ  = 3'd4;

   localparam int PROG_LEN = 12;
   localparam int PC_W     = $clog2(PROG_LEN);

   typedef logic [PC_W-1:0] pc_type;

   typedef struct packed {
      op_type   op;
      hold_type hold_on;
      br_type   br;
      pc_type   target;
   } uword_type;

   typedef struct packed {
      logic   exec;
      logic   take_req;
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic unit_busy;
      logic out_free;
      logic m_zero;
      logic r1_zero;
      logic rem_nz;
   } status_type;

endpackage

FILE: hw/rtl/lcs_arith.sv
// Bit-serial arithmetic unit: restoring divider and shift-add modular multiplier.
module lcs_arith #(
   parameter int WIDTH = lcs_pkg::DATA_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             mul_mode,
   input  logic [WIDTH-1:0] opnd_x,
   input  logic [WIDTH-1:0] opnd_y,
   input  logic [WIDTH-1:0] modulus,
   output logic             busy,
   output logic [WIDTH-1:0] quot,
   output logic [WIDTH-1:0] rem
);
   import lcs_pkg::*;

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] sh_ff, sh_in;
   logic [WIDTH-1:0] base_ff, base_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             mode_ff, mode_in;
   logic [WIDTH+1:0] trial;

   // (x + y) mod m for x, y < m
   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
      logic [WIDTH:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[WIDTH-1:0];
   endfunction

   assign trial = {1'b0, acc_ff, sh_ff[WIDTH-1]} - {2'b00, base_ff};

   always_comb begin
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      base_in = base_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      mode_in = mode_ff;
      if (start) begin
         mode_in = mul_mode;
         busy_in = 1'b1;
         acc_in  = '0;
         cnt_in  = CNT_W'(WIDTH);
         if (mul_mode) begin
            base_in = opnd_x;
            sh_in   = opnd_y;
         end else begin
            sh_in   = opnd_x;
            base_in = opnd_y;
         end
      end else if (busy_ff) begin
         if (mode_ff) begin
            // multiply: one multiplier bit per cycle, stop when none left
            if (sh_ff == '0) begin
               busy_in = 1'b0;
            end else begin
               if (sh_ff[0]) begin
                  acc_in = add_mod(acc_ff, base_ff, modulus);
               end
               base_in = add_mod(base_ff, base_ff, modulus);
               sh_in   = sh_ff >> 1;
            end
         end else begin
            // divide: one quotient bit per cycle
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
            end else begin
               if (!trial[WIDTH+1]) begin
                  acc_in = trial[WIDTH-1:0];
               end else begin
                  acc_in = {acc_ff[WIDTH-2:0], sh_ff[WIDTH-1]};
               end
               sh_in  = {sh_ff[WIDTH-2:0], ~trial[WIDTH+1]};
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      sh_ff   <= sh_in;
      base_ff <= base_in;
      if (reset) begin
         busy_ff <= 1'b0;
         mode_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign busy = busy_ff;
   assign quot = sh_ff;
   assign rem  = acc_ff;

endmodule

FILE: hw/rtl/lcs_datapath.sv
// Datapath: Euclid registers, coefficient registers, arithmetic unit and result register.
module lcs_datapath #(
   parameter int WIDTH = lcs_pkg::DATA_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lcs_pkg::ctrl_type    ctrl,
   output lcs_pkg::status_type status,
   input  logic [WIDTH-1:0]     req_coef_a,
   input  logic [WIDTH-1:0]     req_rhs_b,
   input  logic [WIDTH-1:0]     req_modulus,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WIDTH-1:0]     rsp_divisor,
   output logic [WIDTH-1:0]     rsp_solution,
   output logic                 rsp_solvable
);
   import lcs_pkg::*;

   logic [WIDTH-1:0] a_ff, b_ff, m_ff;
   logic [WIDTH-1:0] r0_ff, r1_ff, s0_ff, s1_ff, x_ff;
   logic [WIDTH-1:0] rem_ff;
   logic             ok_ff;
   logic [WIDTH-1:0] rsp_divisor_ff, rsp_solution_ff;
   logic             rsp_solvable_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             unit_start, unit_mul;
   logic [WIDTH-1:0] unit_x, unit_y;
   logic             unit_busy;
   logic [WIDTH-1:0] unit_quot, unit_rem;
   logic [WIDTH-1:0] s_diff;

   lcs_arith #(.WIDTH(WIDTH)) u_arith (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start),
      .mul_mode (unit_mul),
      .opnd_x   (unit_x),
      .opnd_y   (unit_y),
      .modulus  (m_ff),
      .busy     (unit_busy),
      .quot     (unit_quot),
      .rem      (unit_rem)
   );

   always_comb begin
      unit_start = 1'b0;
      unit_mul   = 1'b0;
      unit_x     = r0_ff;
      unit_y     = r1_ff;
      unique case (ctrl.op)
         OP_DIV_EUCL: begin
            unit_start = ctrl.exec;
         end
         OP_MUL_COEF: begin
            unit_start = ctrl.exec;
            unit_mul   = 1'b1;
            unit_x     = s1_ff;
            unit_y     = unit_quot;
         end
         OP_DIV_RHS: begin
            unit_start = ctrl.exec;
            unit_x     = b_ff;
            unit_y     = r0_ff;
         end
         OP_MUL_SOL: begin
            unit_start = ctrl.exec;
            unit_mul   = 1'b1;
            unit_x     = s0_ff;
            unit_y     = unit_quot;
         end
         default: begin
            unit_start = 1'b0;
         end
      endcase
   end

   // (s0 - q*s1) mod m; wrap back into range with one add of m
   assign s_diff = (s0_ff >= unit_rem) ? (s0_ff - unit_rem) : (s0_ff - unit_rem + m_ff);

   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         unique case (ctrl.op)
            OP_LOAD: begin
               a_ff  <= req_coef_a;
               b_ff  <= req_rhs_b;
               m_ff  <= req_modulus;
               r0_ff <= req_modulus;
               r1_ff <= req_coef_a;
               s0_ff <= '0;
               s1_ff <= {{(WIDTH-1){1'b0}}, (req_modulus != WIDTH'(1))};
               x_ff  <= '0;
               ok_ff <= 1'b0;
            end
            OP_MUL_COEF: begin
               // hold the Euclid remainder before the multiply overwrites it
               rem_ff <= unit_rem;
            end
            OP_UPDATE: begin
               r0_ff <= r1_ff;
               r1_ff <= rem_ff;
               s0_ff <= s1_ff;
               s1_ff <= s_diff;
            end
            OP_SET_OK: begin
               x_ff  <= unit_rem;
               ok_ff <= 1'b1;
            end
            OP_ZERO_MOD: begin
               r0_ff <= a_ff;
            end
            OP_SEND: begin
               rsp_divisor_ff  <= r0_ff;
               rsp_solution_ff <= x_ff;
               rsp_solvable_ff <= ok_ff;
            end
            default: begin
               ok_ff <= ok_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.exec && ctrl.op == OP_SEND) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.unit_busy = unit_busy;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.m_zero    = (m_ff == '0);
   assign status.r1_zero   = (r1_ff == '0);
   assign status.rem_nz    = (unit_rem != '0);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_divisor  = rsp_divisor_ff;
   assign rsp_solution = rsp_solution_ff;
   assign rsp_solvable = rsp_solvable_ff;

endmodule

FILE: hw/rtl/lcs_sequencer.sv
// Microcode sequencer: program ROM, step counter, wait and branch logic.
module lcs_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  lcs_pkg::status_type status,
   output lcs_pkg::ctrl_type   ctrl
);
   import lcs_pkg::*;

   localparam pc_type STEP_IDLE   = PC_W'(0);
   localparam pc_type STEP_MCHK   = PC_W'(1);
   localparam pc_type STEP_LOOP   = PC_W'(2);
   localparam pc_type STEP_DIV    = PC_W'(3);
   localparam pc_type STEP_MUL    = PC_W'(4);
   localparam pc_type STEP_UPD    = PC_W'(5);
   localparam pc_type STEP_FIN    = PC_W'(6);
   localparam pc_type STEP_TEST   = PC_W'(7);
   localparam pc_type STEP_SOLVE  = PC_W'(8);
   localparam pc_type STEP_SETOK  = PC_W'(9);
   localparam pc_type STEP_OUT    = PC_W'(10);
   localparam pc_type STEP_ZMOD   = PC_W'(11);

   function automatic uword_type rom(input pc_type pc);
      uword_type w;
      w = '{op: OP_NOP, hold_on: HOLD_NONE, br: BR_ALWAYS, target: STEP_IDLE};
      unique case (pc)
         STEP_IDLE:  w = '{op: OP_LOAD,     hold_on: HOLD_REQ,  br: BR_NONE,
                           target: STEP_IDLE};
         STEP_MCHK:  w = '{op: OP_NOP,      hold_on: HOLD_NONE, br: BR_M_ZERO,
                           target: STEP_ZMOD};
         STEP_LOOP:  w = '{op: OP_NOP,      hold_on: HOLD_NONE, br: BR_R1_ZERO,
                           target: STEP_FIN};
         STEP_DIV:   w = '{op: OP_DIV_EUCL, hold_on: HOLD_NONE, br: BR_NONE,
                           target: STEP_IDLE};
         STEP_MUL:   w = '{op: OP_MUL_COEF, hold_on: HOLD_UNIT, br: BR_NONE,
                           target: STEP_IDLE};
         STEP_UPD:   w = '{op: OP_UPDATE,   hold_on: HOLD_UNIT, br: BR_ALWAYS,
                           target: STEP_LOOP};
         STEP_FIN:   w = '{op: OP_DIV_RHS,  hold_on: HOLD_NONE, br: BR_NONE,
                           target: STEP_IDLE};
         STEP_TEST:  w = '{op: OP_NOP,      hold_on: HOLD_UNIT, br: BR_REM_NZ,
                           target: STEP_OUT};
         STEP_SOLVE: w = '{op: OP_MUL_SOL,  hold_on: HOLD_NONE, br: BR_NONE,
                           target: STEP_IDLE};
         STEP_SETOK: w = '{op: OP_SET_OK,   hold_on: HOLD_UNIT, br: BR_NONE,
                           target: STEP_IDLE};
         STEP_OUT:   w = '{op: OP_SEND,     hold_on: HOLD_OUT,  br: BR_ALWAYS,
                           target: STEP_IDLE};
         STEP_ZMOD:  w = '{op: OP_ZERO_MOD, hold_on: HOLD_NONE, br: BR_ALWAYS,
                           target: STEP_OUT};
         default:    w = '{op: OP_NOP,      hold_on: HOLD_NONE, br: BR_ALWAYS,
                           target: STEP_IDLE};
      endcase
      return w;
   endfunction

   pc_type    pc_ff, pc_in;
   uword_type word;
   logic      go;
   logic      taken;

   assign word = rom(pc_ff);

   always_comb begin
      unique case (word.hold_on)
         HOLD_NONE: go = 1'b1;
         HOLD_REQ:  go = req_valid;
         HOLD_UNIT: go = !status.unit_busy;
         HOLD_OUT:  go = status.out_free;
         default:   go = 1'b0;
      endcase
   end

   always_comb begin
      unique case (word.br)
         BR_NONE:    taken = 1'b0;
         BR_ALWAYS:  taken = 1'b1;
         BR_M_ZERO:  taken = status.m_zero;
         BR_R1_ZERO: taken = status.r1_zero;
         BR_REM_NZ:  taken = status.rem_nz;
         default:    taken = 1'b0;
      endcase
   end

   always_comb begin
      pc_in = pc_ff;
      if (go) begin
         pc_in = taken ? word.target : pc_ff + PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.exec     = go;
   assign ctrl.take_req = (word.hold_on == HOLD_REQ);
   assign ctrl.op       = word.op;

endmodule

FILE: hw/rtl/linear_congruence_solver.sv
// Top level of the linear congruence solver.
// Solves a*x = b (mod m) one word at a time: the extended Euclidean algorithm on (m, a)
// gives g = gcd(a, m) and the coefficient s of a, then x = s*(b/g) mod m when g divides b,
// else solvable is low and solution is zero; m = 0 returns g = a and no solution. A small
// microcode program steps one shared bit-serial unit that divides (one quotient bit per
// cycle) or multiplies modulo m (one multiplier bit per cycle, stopping once no multiplier
// bits are left). A new request word is taken once the previous result sits in the output
// register, even while that result is still stalled.
module linear_congruence_solver #(
   parameter int WIDTH = lcs_pkg::DATA_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [WIDTH-1:0] req_coef_a,
   input  logic [WIDTH-1:0] req_rhs_b,
   input  logic [WIDTH-1:0] req_modulus,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [WIDTH-1:0] rsp_divisor,
   output logic [WIDTH-1:0] rsp_solution,
   output logic             rsp_solvable
);
   import lcs_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   lcs_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .ctrl      (ctrl)
   );

   lcs_datapath #(.WIDTH(WIDTH)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .status       (status),
      .req_coef_a   (req_coef_a),
      .req_rhs_b    (req_rhs_b),
      .req_modulus  (req_modulus),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_divisor  (rsp_divisor),
      .rsp_solution (rsp_solution),
      .rsp_solvable (rsp_solvable)
   );

   assign req_stall = !ctrl.take_req;

endmodule
